[rtl/irclt_pkg.sv]
`timescale 1ns / 1ps
package irclt_pkg;

  localparam int HOLD_DEPTH_DEF = 8;
  localparam int MAX_PARAMS_DEF = 15;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_PREFIX   = 3'd1,
    MODE_COMMAND  = 3'd2,
    MODE_PARAMS   = 3'd3,
    MODE_TRAILING = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    CLS_PREFIX   = 3'd0,
    CLS_COMMAND  = 3'd1,
    CLS_PARAM    = 3'd2,
    CLS_TRAILING = 3'd3,
    CLS_DELIM    = 3'd4,
    CLS_STRIPPED = 3'd5
  } class_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD   = 2'd1,
    S_SEND = 2'd2,
    S_BYTE = 2'd3
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // capture the input item
    logic hold_live;  // push the incoming CR/LF into the hold store
    logic rd_issue;   // read the hold store at the release index
    logic emit_held;  // load a released held byte into the output register
    logic emit_byte;  // load the item's own byte into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_crlf;    // incoming byte is CR or LF
    logic in_eol;     // incoming item ends the line
    logic held_empty;
    logic held_full;
    logic rel_last;   // release index points at the last held byte
    logic saved_ovf;  // captured item is a CR/LF that overflowed the store
    logic out_free;   // output register can take a result this cycle
  } ctrl_sts_t;

  typedef struct packed {
    logic [7:0] ob;
    class_t     cls;
    logic       lim;
    mode_t      mode;
    logic [3:0] pcount;
    logic       ats;
  } cls_res_t;

  // Label one content byte and work out the parser state after it
  function automatic cls_res_t classify(mode_t mode, logic [3:0] pcount, logic ats,
                                        logic [7:0] b, logic [3:0] cap);
    cls_res_t r;
    mode_t    m;
    r.ob     = b;
    r.lim    = 1'b0;
    r.mode   = mode;
    r.pcount = pcount;
    r.ats    = ats;
    r.cls    = CLS_DELIM;
    m        = mode;
    if (mode == MODE_START && b == CH_COLON) begin
      r.mode = MODE_PREFIX;
      r.cls  = CLS_DELIM;
    end else begin
      if (mode == MODE_START) m = MODE_COMMAND;
      r.mode = m;
      case (m)
        MODE_PREFIX: begin
          if (b == CH_SPACE) begin
            r.mode = MODE_COMMAND;
            r.cls  = CLS_DELIM;
          end else begin
            r.cls = CLS_PREFIX;
          end
        end
        MODE_COMMAND: begin
          if (b == CH_SPACE) begin
            r.mode = MODE_PARAMS;
            r.ats  = 1'b1;
            r.cls  = CLS_DELIM;
          end else begin
            if (b >= CH_LC_A && b <= CH_LC_Z) r.ob = b - CASE_OFS;
            r.cls = CLS_COMMAND;
          end
        end
        MODE_PARAMS: begin
          if (ats && b == CH_COLON) begin
            r.mode = MODE_TRAILING;
            r.cls  = CLS_DELIM;
          end else if (b == CH_SPACE) begin
            if (pcount >= cap) r.lim = 1'b1;
            else r.pcount = pcount + 4'd1;
            r.ats = 1'b1;
            r.cls = CLS_DELIM;
          end else begin
            r.ats = 1'b0;
            r.cls = CLS_PARAM;
          end
        end
        default: begin
          r.mode = MODE_TRAILING;
          r.cls  = CLS_TRAILING;
        end
      endcase
    end
    return r;
  endfunction

endpackage

[rtl/irclt_ram.sv]
`timescale 1ns / 1ps
module irclt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

[rtl/irclt_ctrl.sv]
`timescale 1ns / 1ps
module irclt_ctrl
  import irclt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      data_valid,
  output logic      data_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    data_ready = 1'b0;
    case (state)
      S_IDLE: begin
        data_ready = 1'b1;
        if (data_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_crlf && !sts.in_eol && !sts.held_full) cmd.hold_live = 1'b1;
          else if (sts.held_empty) state_next = S_BYTE;
          else state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_SEND;
      end
      S_SEND: begin
        if (sts.out_free) begin
          cmd.emit_held = 1'b1;
          if (!sts.rel_last) state_next = S_RD;
          else if (sts.saved_ovf) state_next = S_IDLE;
          else state_next = S_BYTE;
        end
      end
      S_BYTE: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/irclt_dp.sv]
`timescale 1ns / 1ps
module irclt_dp
  import irclt_pkg::*;
#(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       end_of_line,
  input  ctrl_cmd_t  cmd,
  output ctrl_sts_t  sts,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic [2:0] field_class,
  output logic [3:0] param_index,
  output logic       run_last,
  output logic       line_done,
  output logic       limit_reached
);

  localparam int AW      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW      = $clog2(HOLD_DEPTH + 1);
  localparam int CAP_INT = (MAX_PARAMS < 15) ? MAX_PARAMS : 15;
  localparam logic [3:0]    PARAM_CAP = 4'(CAP_INT);
  localparam logic [CW-1:0] HOLD_MAX  = CW'(HOLD_DEPTH);

  // Parser state
  mode_t         mode;
  logic [3:0]    param_count;
  logic          at_token_start;
  logic [CW-1:0] held_count;
  logic [AW-1:0] rel_idx;

  // Captured item
  logic [7:0] byte_r;
  logic       eol_r;
  logic       crlf_r;

  logic          in_crlf;
  logic          saved_strip;
  logic          saved_ovf;
  logic          rel_last;
  logic          held_kind;
  logic [7:0]    held_byte;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  cls_res_t      res_held;
  cls_res_t      res_byte;

  assign in_crlf     = (data_byte == CH_CR) || (data_byte == CH_LF);
  assign saved_strip = crlf_r && eol_r;
  assign saved_ovf   = crlf_r && !eol_r;
  assign rel_last    = (CW'(rel_idx) + CW'(1)) == held_count;
  assign held_byte   = held_kind ? CH_LF : CH_CR;

  assign res_held = classify(mode, param_count, at_token_start, held_byte, PARAM_CAP);
  assign res_byte = classify(mode, param_count, at_token_start, byte_r, PARAM_CAP);

  // Status to controller
  always_comb begin
    sts.in_crlf    = in_crlf;
    sts.in_eol     = end_of_line;
    sts.held_empty = (held_count == '0);
    sts.held_full  = (held_count == HOLD_MAX);
    sts.rel_last   = rel_last;
    sts.saved_ovf  = saved_ovf;
    sts.out_free   = !result_valid || result_ready;
  end

  // Hold store: live CR/LF push, or restart with the overflowing byte
  assign ram_we    = cmd.hold_live || (cmd.emit_held && rel_last && saved_ovf);
  assign ram_waddr = cmd.hold_live ? held_count[AW-1:0] : '0;
  assign ram_wdata = cmd.hold_live ? (data_byte == CH_LF) : (byte_r == CH_LF);

  irclt_ram #(
    .WIDTH (1),
    .DEPTH (HOLD_DEPTH),
    .AW    (AW)
  ) u_hold (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (rel_idx),
    .rdata (held_kind)
  );

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= data_byte;
      eol_r  <= end_of_line;
      crlf_r <= in_crlf;
    end
  end

  // Parser state and hold bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_START;
      param_count    <= '0;
      at_token_start <= 1'b1;
      held_count     <= '0;
      rel_idx        <= '0;
    end else begin
      if (cmd.hold_live) held_count <= held_count + CW'(1);
      if (cmd.emit_held) begin
        if (!saved_strip) begin
          mode           <= res_held.mode;
          param_count    <= res_held.pcount;
          at_token_start <= res_held.ats;
        end
        if (rel_last) begin
          rel_idx    <= '0;
          held_count <= saved_ovf ? CW'(1) : '0;
        end else begin
          rel_idx <= rel_idx + AW'(1);
        end
      end
      if (cmd.emit_byte) begin
        if (eol_r) begin
          mode           <= MODE_START;
          param_count    <= '0;
          at_token_start <= 1'b1;
          held_count     <= '0;
        end else if (!crlf_r) begin
          mode           <= res_byte.mode;
          param_count    <= res_byte.pcount;
          at_token_start <= res_byte.ats;
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (cmd.emit_held || cmd.emit_byte) result_valid <= 1'b1;
    else if (result_ready) result_valid <= 1'b0;
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit_held) begin
      run_last  <= rel_last && saved_ovf;
      line_done <= 1'b0;
      if (saved_strip) begin
        out_byte      <= held_byte;
        field_class   <= CLS_STRIPPED;
        param_index   <= param_count;
        limit_reached <= 1'b0;
      end else begin
        out_byte      <= res_held.ob;
        field_class   <= res_held.cls;
        param_index   <= res_held.pcount;
        limit_reached <= res_held.lim || saved_ovf;
      end
    end else if (cmd.emit_byte) begin
      run_last  <= 1'b1;
      line_done <= eol_r;
      if (crlf_r) begin
        out_byte      <= byte_r;
        field_class   <= CLS_STRIPPED;
        param_index   <= param_count;
        limit_reached <= 1'b0;
      end else begin
        out_byte      <= res_byte.ob;
        field_class   <= res_byte.cls;
        param_index   <= res_byte.pcount;
        limit_reached <= res_byte.lim;
      end
    end
  end

endmodule

[rtl/irc_line_tokenizer_top.sv]
`timescale 1ns / 1ps
// Channel  Handshake                    Payload
// input    data_valid / data_ready      data_byte, end_of_line
// result   result_valid / result_ready  out_byte, field_class, param_index,
//                                       run_last, line_done, limit_reached
//
// A CR/LF held without overflow gives no result; one that overflows the full store
// releases the held bytes and then starts the store anew with itself. Any other item
// releases the held CR/LF bytes, then its own byte: each held byte needs one hold store read and one output load.
// Reset (rst, synchronous) clears the parser and the hold count; the hold store
// itself is not cleared, since only entries below the count are read.
// A low result_ready holds the controller in its emit step; no result is dropped.
module irc_line_tokenizer_top
  import irclt_pkg::*;
#(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_line,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic [2:0] field_class,
  output logic [3:0] param_index,
  output logic       run_last,
  output logic       line_done,
  output logic       limit_reached
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  irclt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  irclt_dp #(
    .HOLD_DEPTH (HOLD_DEPTH),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .end_of_line   (end_of_line),
    .cmd           (cmd),
    .sts           (sts),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .out_byte      (out_byte),
    .field_class   (field_class),
    .param_index   (param_index),
    .run_last      (run_last),
    .line_done     (line_done),
    .limit_reached (limit_reached)
  );

endmodule

[rtl/irclt_checker.sv]
`timescale 1ns / 1ps
module irclt_checker
  import irclt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] out_byte,
  input logic [2:0] field_class,
  input logic       run_last,
  input logic       line_done,
  input logic       limit_reached
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_byte)
      && $stable(field_class))
    else $error("result changed while stalled");

  // Class code stays in range
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> field_class <= CLS_STRIPPED)
    else $error("field class out of range");

  // End of line closes the run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && line_done |-> run_last)
    else $error("line done without run last");

  // Stripped bytes never carry the limit flag
  a_strip_nolim: assert property (@(posedge clk) disable iff (rst)
    result_valid && field_class == CLS_STRIPPED |-> !limit_reached)
    else $error("limit on stripped byte");

  // Command bytes come out upper-cased
  a_cmd_upper: assert property (@(posedge clk) disable iff (rst)
    result_valid && field_class == CLS_COMMAND |-> (out_byte < CH_LC_A || out_byte > CH_LC_Z))
    else $error("lower-case command byte");

endmodule

bind irc_line_tokenizer_top irclt_checker u_irclt_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .out_byte      (out_byte),
  .field_class   (field_class),
  .run_last      (run_last),
  .line_done     (line_done),
  .limit_reached (limit_reached)
);
